### rtl/wpr_pkg.sv
// shared types and constants of the windowed peak reporter
package wpr_pkg;

  localparam int unsigned LoadW = 16;
  localparam int unsigned TsW   = 48;
  localparam int unsigned EndW  = TsW + 1;
  localparam int unsigned LenW  = 13;
  localparam int unsigned WinW  = 24;

  localparam logic [WinW-1:0] WindowReset = 24'd24000;

  // at most this many reports per transaction
  localparam int unsigned MaxResults = 33;
  localparam int unsigned ResCntW    = $clog2(MaxResults + 1);

  // both internal queues; depth must be a power of two
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [LoadW-1:0] load_value;
    logic [TsW-1:0]   block_start;
    logic [LenW-1:0]  block_length;
  } wpr_in_t;

  typedef struct packed {
    logic [TsW-1:0]   window_end;
    logic [LoadW-1:0] window_peak;
    logic             last_of_run;
  } wpr_out_t;

  // classified block handed from front to back
  typedef struct packed {
    logic [LoadW-1:0] load_value;
    logic [TsW-1:0]   block_start;
    logic [EndW-1:0]  block_end;
  } wpr_job_t;

  typedef enum logic {
    BackIdle,
    BackRun
  } wpr_back_state_e;

endpackage

### rtl/wpr_front.sv
// front end: accepts block reports, drops empty blocks, queues jobs for the back end
module wpr_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  input  wpr_pkg::wpr_in_t in_item_i,
  output logic             full,
  output logic             job_valid_o,
  output wpr_pkg::wpr_job_t job_o,
  input  logic             job_pop_i
);
  import wpr_pkg::*;

  wpr_job_t           q_mem [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]   cnt_q, cnt_d;
  logic               accept;
  logic               keep;
  logic               take;
  wpr_job_t           job_new;

  assign full        = (cnt_q == QCntW'(QDepth));
  assign job_valid_o = (cnt_q != '0);
  assign job_o       = q_mem[rd_ptr_q];

  assign accept = push && !full;
  // a zero-length block changes nothing, so it never reaches the back end
  assign keep   = accept && (in_item_i.block_length != '0);
  assign take   = job_pop_i && job_valid_o;

  always_comb begin
    job_new.load_value  = in_item_i.load_value;
    job_new.block_start = in_item_i.block_start;
    job_new.block_end   = {1'b0, in_item_i.block_start} + EndW'(in_item_i.block_length);
  end

  always_comb begin
    wr_ptr_d = keep ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = take ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (keep && !take) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!keep && take) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (keep) begin
      q_mem[wr_ptr_q] <= job_new;
    end
  end

endmodule

### rtl/wpr_back.sv
// back end: window tracking, one report per cycle into the result queue while that queue has room
module wpr_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  wpr_pkg::wpr_job_t job_i,
  output logic              job_pop_o,
  input  logic [wpr_pkg::WinW-1:0] win_len_i,
  input  logic              restart_i,
  output logic              empty,
  input  logic              pop,
  output wpr_pkg::wpr_out_t out_item_o
);
  import wpr_pkg::*;

  wpr_back_state_e     state_q, state_d;
  wpr_job_t            job_q, job_d;
  logic                started_q, started_d;
  logic [TsW-1:0]      next_end_q, next_end_d;
  logic [LoadW-1:0]    peak_q, peak_d;
  logic [ResCntW-1:0]  res_cnt_q, res_cnt_d;

  logic [TsW-1:0]      end_nxt;
  logic                due;
  logic                more;
  logic                res_push;
  wpr_out_t            res;

  wpr_out_t            oq_mem [QDepth];
  logic [QPtrW-1:0]    oq_wr_q, oq_rd_q;
  logic [QCntW-1:0]    oq_cnt_q, oq_cnt_d;
  logic                oq_take;
  logic                oq_room;

  assign oq_room = (oq_cnt_q != QCntW'(QDepth));
  assign oq_take = pop && !empty;
  assign empty   = (oq_cnt_q == '0);
  assign out_item_o = oq_mem[oq_rd_q];

  assign end_nxt = next_end_q + TsW'(win_len_i);
  assign due     = (job_q.block_end >= {1'b0, next_end_q});
  // another window end still fits in this block and in the report limit
  assign more    = ((res_cnt_q + 1'b1) < ResCntW'(MaxResults))
                && (job_q.block_end >= {1'b0, end_nxt});

  always_comb begin
    state_d    = state_q;
    job_d      = job_q;
    started_d  = started_q;
    next_end_d = next_end_q;
    peak_d     = peak_q;
    res_cnt_d  = res_cnt_q;
    job_pop_o  = 1'b0;
    res_push   = 1'b0;
    res.window_end  = next_end_q;
    res.window_peak = peak_q;
    res.last_of_run = !more;
    case (state_q)
      BackIdle: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          started_d = 1'b1;
          res_cnt_d = '0;
          state_d   = BackRun;
          if (!started_q) begin
            next_end_d = job_i.block_start + TsW'(win_len_i);
            peak_d     = job_i.load_value;
          end else if (job_i.load_value > peak_q) begin
            peak_d = job_i.load_value;
          end
        end
      end
      BackRun: begin
        if (!due) begin
          state_d = BackIdle;
        end else if (oq_room) begin
          res_push   = 1'b1;
          next_end_d = end_nxt;
          peak_d     = job_q.load_value;
          res_cnt_d  = res_cnt_q + 1'b1;
          if (!more) begin
            state_d = BackIdle;
          end
        end
      end
      default: begin
        state_d = BackIdle;
      end
    endcase
    // a new window length reopens the window on the next transaction
    if (restart_i) begin
      started_d = 1'b0;
    end
  end

  always_comb begin
    oq_cnt_d = oq_cnt_q;
    if (res_push && !oq_take) begin
      oq_cnt_d = oq_cnt_q + 1'b1;
    end else if (!res_push && oq_take) begin
      oq_cnt_d = oq_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BackIdle;
      started_q  <= 1'b0;
      next_end_q <= '0;
      peak_q     <= '0;
      res_cnt_q  <= '0;
      oq_wr_q    <= '0;
      oq_rd_q    <= '0;
      oq_cnt_q   <= '0;
    end else begin
      state_q    <= state_d;
      started_q  <= started_d;
      next_end_q <= next_end_d;
      peak_q     <= peak_d;
      res_cnt_q  <= res_cnt_d;
      oq_cnt_q   <= oq_cnt_d;
      if (res_push) begin
        oq_wr_q <= oq_wr_q + 1'b1;
      end
      if (oq_take) begin
        oq_rd_q <= oq_rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (res_push) begin
      oq_mem[oq_wr_q] <= res;
    end
  end

  a_oq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oq_cnt_q <= QCntW'(QDepth))
    else $error("result queue overfilled");

  a_res_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BackRun |-> res_cnt_q < ResCntW'(MaxResults))
    else $error("report limit exceeded");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push && res.last_of_run |=> state_q == BackIdle)
    else $error("sequencer kept running after last report");

  a_end_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> {1'b0, res.window_end} <= job_q.block_end)
    else $error("reported window end lies past the block");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |-> state_q == BackIdle && job_valid_i)
    else $error("job taken while busy");

endmodule

### rtl/windowed_peak_reporter.sv
// top level of the windowed peak reporter
// Input channel: a block report (load, start timestamp, sample count) is one
// transaction, taken at a clock edge with push high and full low. Reports with
// a zero sample count are taken and dropped. A two-entry queue holds reports
// until the window sequencer is free.
// Output channel: while empty is low, out_item_o carries the oldest window
// report (end timestamp, peak load, last-of-run flag); pop takes it.
// An accepted transaction passes the input queue, the sequencer's job register
// and the result queue before its first report shows. The sequencer loads each
// transaction, then pushes one report per cycle while the result queue has room,
// up to 33 reports; with no window end in the block it loads and checks only.
// The sequencer pushes into a two-entry result queue; when pop stays low the
// queue fills, the sequencer holds, and then the input queue fills and full
// rises. Nothing is dropped.
// cfg_we_i writes the window length (zero acts as one) and forces the next
// transaction to open a fresh window; write only while the block is idle.
// Reset empties both queues, sets the window length to 24000 and leaves no
// window open.
module windowed_peak_reporter (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  wpr_pkg::wpr_in_t         in_item_i,
  output logic                     empty,
  input  logic                     pop,
  output wpr_pkg::wpr_out_t        out_item_o,
  input  logic                     cfg_we_i,
  input  logic [wpr_pkg::WinW-1:0] cfg_wdata_i
);
  import wpr_pkg::*;

  logic [WinW-1:0] win_q;
  logic [WinW-1:0] win_len;
  logic            job_valid;
  logic            job_pop;
  wpr_job_t        job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WindowReset;
    end else if (cfg_we_i) begin
      win_q <= cfg_wdata_i;
    end
  end

  assign win_len = (win_q == '0) ? WinW'(1) : win_q;

  wpr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .in_item_i   (in_item_i),
    .full        (full),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  wpr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .win_len_i   (win_len),
    .restart_i   (cfg_we_i),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o)
  );

endmodule

### bench/wpr_checker.sv
// checker for the windowed peak reporter: predicts window reports and compares them
module wpr_checker
  import wpr_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic            full_i,
  input  wpr_in_t         in_item_i,
  input  logic            empty_i,
  input  logic            pop_i,
  input  wpr_out_t        out_item_i,
  input  logic            cfg_we_i,
  input  logic [WinW-1:0] cfg_wdata_i,
  output int              fail_count_o,
  output int              pending_o,
  output int              reports_o
);

  logic [WinW-1:0]  win_len;
  logic             window_open;
  logic [TsW-1:0]   next_close;
  logic [LoadW-1:0] peak_now;
  wpr_out_t         reports_due[$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    reports_o    = 0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    fail_count_o++;
    $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
  endtask

  task automatic predict_window_reports(input wpr_in_t blk);
    logic [TsW-1:0]  span;
    logic [EndW-1:0] blk_end;
    int unsigned     n;
    wpr_out_t        rpt;
    if (blk.block_length == '0) return;
    // a zero length acts as a window of one sample
    span = (win_len == '0) ? TsW'(1) : TsW'(win_len);
    if (!window_open) begin
      window_open = 1'b1;
      next_close  = blk.block_start + span;
      peak_now    = blk.load_value;
    end else if (blk.load_value > peak_now) begin
      peak_now = blk.load_value;
    end
    blk_end = EndW'(blk.block_start) + EndW'(blk.block_length);
    n = 0;
    while (n < MaxResults && blk_end >= EndW'(next_close)) begin
      rpt.window_end  = next_close;
      rpt.window_peak = peak_now;
      next_close      = next_close + span;
      peak_now        = blk.load_value;
      n++;
      rpt.last_of_run = (n == MaxResults) || (blk_end < EndW'(next_close));
      reports_due.push_back(rpt);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    wpr_out_t want;
    if (!rst_ni) begin
      win_len     = WindowReset;
      window_open = 1'b0;
      next_close  = '0;
      peak_now    = '0;
      reports_due.delete();
    end else begin
      if (pop_i && !empty_i) begin
        reports_o++;
        if (reports_due.size() == 0) begin
          report_mismatch("window report with nothing due, end", out_item_i.window_end, '0);
        end else begin
          want = reports_due.pop_front();
          if (out_item_i.window_end !== want.window_end)
            report_mismatch("window_end", out_item_i.window_end, want.window_end);
          if (out_item_i.window_peak !== want.window_peak)
            report_mismatch("window_peak", out_item_i.window_peak, want.window_peak);
          if (out_item_i.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", out_item_i.last_of_run, want.last_of_run);
        end
      end
      // a write always forces a fresh window on the next block
      if (cfg_we_i) begin
        win_len     = cfg_wdata_i;
        window_open = 1'b0;
      end
      if (push_i && !full_i) begin
        predict_window_reports(in_item_i);
      end
    end
    pending_o = reports_due.size();
  end

endmodule

### bench/testbench.sv
// testbench top for the windowed peak reporter: stimulus, flow control and verdict
module testbench;
  import wpr_pkg::*;

  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned SettleWait  = 16;
  localparam int unsigned TailCycles  = 40;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            push = 1'b0;
  logic            full;
  wpr_in_t         in_item = '0;
  logic            empty;
  logic            pop = 1'b0;
  wpr_out_t        out_item;
  logic            cfg_we = 1'b0;
  logic [WinW-1:0] cfg_wdata = '0;

  int              fail_count;
  int              pending;
  int              reports_seen;

  int unsigned     gap_pct = 14;
  int unsigned     recv_idle_pct = 46;
  int unsigned     cur_span = 24000;
  logic            hold_off_go = 1'b0;
  logic            hold_off_done = 1'b0;
  int unsigned     blocks_sent = 0;
  int unsigned     empty_sent = 0;
  int unsigned     writes_done = 0;

  windowed_peak_reporter u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  wpr_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_i      (full),
    .in_item_i   (in_item),
    .empty_i     (empty),
    .pop_i       (pop),
    .out_item_i  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .reports_o   (reports_seen)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

  // result side; one long hold-off lets the block back up into its input
  initial begin : receiver
    int unsigned held;
    held = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_go && !hold_off_done) begin
        pop <= 1'b0;
        held++;
        if (held == HoldCycles) hold_off_done = 1'b1;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_block(input logic [LoadW-1:0] load, input logic [TsW-1:0] start,
                            input logic [LenW-1:0] len);
    while ($urandom_range(0, 99) < gap_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= '{load_value: load, block_start: start, block_length: len};
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    blocks_sent++;
    if (len == '0) empty_sent++;
  endtask

  // let every due report come out and the sequencer run dry
  task automatic drain_and_wait();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [WinW-1:0] len);
    cfg_wdata <= len;
    cfg_we    <= 1'b1;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    cur_span  = (len == '0) ? 1 : int'(len);
    writes_done++;
  endtask

  // mostly back-to-back blocks on one timeline, with gaps, jumps and empty blocks mixed in
  task automatic random_run(input int unsigned n_blocks);
    logic [TsW-1:0]   ts;
    logic [LenW-1:0]  len;
    logic [LoadW-1:0] load;
    int unsigned      done;
    int unsigned      roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) ts = TsW'($urandom);
    else if (roll < 75) ts = TsW'({$urandom, $urandom});
    else ts = {TsW{1'b1}} - TsW'($urandom_range(0, 30000));
    done = 0;
    while (done < n_blocks) begin
      load = LoadW'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 8) len = '0;
      else if (roll < 16) len = LenW'($urandom_range(1, 4096));
      else len = LenW'($urandom_range(64, 1024));
      roll = $urandom_range(0, 99);
      if (roll < 6) ts = TsW'({$urandom, $urandom});
      else if (roll < 26) ts = ts + TsW'($urandom_range(0, cur_span));
      send_block(load, ts, len);
      ts = ts + TsW'(len);
      if (len != '0) done++;
    end
  endtask

  initial begin : stimulus
    logic [WinW-1:0] next_win;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset window of 24000
    send_block(16'hFFFF, 48'h0000_1234_5678, 13'd0);
    send_block(16'h0000, 48'd0, 13'd1);
    send_block(16'hFFFF, 48'd1, 13'd4096);
    send_block(16'h8000, 48'd4097, 13'd0);
    send_block(16'h0001, 48'd23000, 13'd1000);
    send_block(16'h0001, 48'd24000, LenW'(24000 % 8192));
    drain_and_wait();
    // zero window acts as one sample, so the block holds more window ends than the per-block cap lets out
    write_window('0);
    send_block(16'h1234, 48'd5, 13'd4096);
    send_block(16'h0FFF, 48'd4200, 13'd1);
    drain_and_wait();
    // longest window, block at the top of the timestamp range
    write_window(24'hFF_FFFF);
    send_block(16'hABCD, 48'hFFFF_FFFF_FFFF, 13'd4096);
    drain_and_wait();
    // same value again still reopens the window
    write_window(24'hFF_FFFF);
    send_block(16'h0010, 48'd0, 13'd1);
    send_block(16'h0020, 48'd16777214, 13'd1);
    drain_and_wait();
    write_window(24'd128);
    send_block(16'h7FFF, 48'd1000, 13'd128);
    send_block(16'h7FFF, 48'd1128, 13'd127);
    send_block(16'h7FFE, 48'd1255, 13'd1);
    send_block(16'hFFFF, 48'd1256, 13'd4096);
    send_block(16'h0000, 48'd5352, 13'd0);

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        gap_pct       = 46;
        recv_idle_pct = 14;
      end else if (ph == 2) begin
        gap_pct       = 0;
        recv_idle_pct = 0;
        drain_and_wait();
        write_window(24'd128);
        hold_off_go = 1'b1;
        random_run(14);
      end
      for (int seg = 0; seg < 4; seg++) begin
        case ((ph * 4 + seg) % 6)
          0:       next_win = 24'd128;
          1:       next_win = WinW'($urandom_range(129, 2000));
          2:       next_win = WindowReset;
          3:       next_win = 24'hFF_FFFF;
          4:       next_win = WinW'($urandom_range(2001, 60000));
          default: next_win = '0;
        endcase
        drain_and_wait();
        write_window(next_win);
        random_run(15);
      end
    end

    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("covered %0d block reports (%0d of them empty) over %0d window length writes",
             blocks_sent, empty_sent, writes_done);
    $display("%0d window reports checked, long output stall %0s", reports_seen,
             hold_off_done ? "done" : "not reached");
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
